FILE: sv/kmnpd_pkg.sv
// ----------------------------------------------------------------------------
// Key matrix new-press detector: shared types and constants
// Field widths, the item codes and the default matrix size.
// ----------------------------------------------------------------------------
package kmnpd_pkg;

  // Default matrix size.
  localparam int ColumnsDef = 24;
  localparam int RowsDef    = 5;

  // Field widths of the items.
  localparam int RowBitsW = 5;
  localparam int KeyW     = 7;
  localparam int RowExtW  = 8;   // row word widened to the largest row count
  localparam int InDataW  = 16;  // row_bits and key_index, padded to bytes
  localparam int OutDataW = 16;  // new_press, key_code and key_down, padded

  // Kind of an input item.
  typedef enum logic [0:0] {
    OpSample = 1'b0,
    OpQuery  = 1'b1
  } op_e;

  // Kind of a result item.
  typedef enum logic [0:0] {
    KindScan  = 1'b0,
    KindQuery = 1'b1
  } res_kind_e;

endpackage

FILE: sv/key_matrix_new_press_detector.sv
// ----------------------------------------------------------------------------
// Key matrix new-press detector
// Takes row samples column by column, reports the first new press of each
// scan at the last column and answers queries on whether a key is held down.
// ----------------------------------------------------------------------------
// A result item passes the stage 1 register and then the output register.
// Throughput: one item per cycle unless a result waits on a full output register; the
// row memories are read on accept and written back from stage 1, with forwarding.
// Reset: the valid bits of both row memories clear at once, so every column
// reads as released; there is no clearing pass and items are taken at once.
module key_matrix_new_press_detector #(
  parameter int COLUMNS = kmnpd_pkg::ColumnsDef,
  parameter int ROWS    = kmnpd_pkg::RowsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input items.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [kmnpd_pkg::InDataW-1:0] s_axis_tdata,  // row_bits[4:0], key_index[11:5]
  input  logic                          s_axis_tuser,  // operation
  // Result items.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [kmnpd_pkg::OutDataW-1:0] m_axis_tdata, // new_press[0], key_code[7:1],
                                                       // key_down[8]
  output logic                          m_axis_tuser   // result_kind
);
  import kmnpd_pkg::*;

  localparam int ColW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RowIdxW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ColW-1:0] LastCol = ColW'(COLUMNS - 1);
  localparam logic [KeyW-1:0] ColsK   = KeyW'(COLUMNS);
  localparam logic [8:0]      KeyCntK = 9'(ROWS * COLUMNS);

  // Unpack the input item.
  op_e                 op_in;
  logic [RowBitsW-1:0] row_bits_in;
  logic [KeyW-1:0]     key_in;
  logic [RowExtW-1:0]  rows_ext;
  logic [ROWS-1:0]     rows_in;

  assign op_in       = op_e'(s_axis_tuser);
  assign row_bits_in = s_axis_tdata[RowBitsW-1:0];
  assign key_in      = s_axis_tdata[RowBitsW+KeyW-1:RowBitsW];
  assign rows_ext    = {{(RowExtW-RowBitsW){1'b0}}, row_bits_in};
  assign rows_in     = rows_ext[ROWS-1:0];

  // Stage 0 and stage 1 control.
  logic            s_acc;
  logic            s1_vld_q;
  op_e             s1_op_q;
  logic            s1_last_q;
  logic [ColW-1:0] s1_col_q;
  logic [ROWS-1:0] s1_rows_q;
  logic            s1_inr_q;
  logic [RowIdxW-1:0] s1_row_q;
  logic            s1_res;
  logic            s1_go;
  logic            s1_fire;
  logic            m_vld_q;

  assign s1_res        = s1_vld_q && ((s1_op_q == OpQuery) || s1_last_q);
  assign s1_go         = !s1_res || !m_vld_q || m_axis_tready;
  assign s1_fire       = s1_vld_q && s1_go;
  assign s_axis_tready = !s1_vld_q || s1_go;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Split a queried key number into row and column by repeated subtraction.
  logic [KeyW-1:0] q_rem;
  logic [3:0]      q_row;
  logic            q_inr;
  logic [ColW-1:0] q_col;

  always_comb begin
    q_rem = key_in;
    q_row = '0;
    for (int i = 0; i < ROWS; i++) begin
      if (q_rem >= ColsK) begin
        q_rem = q_rem - ColsK;
        q_row = q_row + 4'd1;
      end
    end
    q_inr = ({2'b00, key_in} < KeyCntK);
    q_col = q_inr ? q_rem[ColW-1:0] : '0;
  end

  // Column counter: the next column to be sampled.
  logic [ColW-1:0] col_q;
  logic [ColW-1:0] col_d;
  logic [ColW-1:0] rd_addr;

  assign rd_addr = (op_in == OpSample) ? col_q : q_col;

  always_comb begin
    col_d = col_q;
    if (s_acc && (op_in == OpSample)) begin
      col_d = (col_q == LastCol) ? '0 : col_q + ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      col_q <= col_d;
      if (s_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_go) begin
        s1_vld_q <= 1'b0;
      end
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_op_q   <= op_in;
      s1_last_q <= (col_q == LastCol);
      s1_col_q  <= rd_addr;
      s1_rows_q <= rows_in;
      s1_inr_q  <= q_inr;
      s1_row_q  <= q_row[RowIdxW-1:0];
    end
  end

  // Write-back enables from stage 1.
  logic hit_seen_q;
  logic cur_we;
  logic prev_we;

  assign cur_we  = s1_fire && (s1_op_q == OpSample);
  assign prev_we = cur_we && !hit_seen_q;

  // Valid bits: an entry not yet written reads as all released.
  logic [COLUMNS-1:0] cur_vld_q;
  logic [COLUMNS-1:0] prev_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q  <= '0;
      prev_vld_q <= '0;
    end else begin
      if (cur_we) begin
        cur_vld_q[s1_col_q] <= 1'b1;
      end
      if (prev_we) begin
        prev_vld_q[s1_col_q] <= 1'b1;
      end
    end
  end

  // Row memories with registered read data.
  logic [ROWS-1:0] cur_mem  [COLUMNS];
  logic [ROWS-1:0] prev_mem [COLUMNS];
  logic [ROWS-1:0] cur_raw_q;
  logic [ROWS-1:0] prev_raw_q;

  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[s1_col_q] <= s1_rows_q;
    end
    if (s_acc) begin
      cur_raw_q <= cur_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[s1_col_q] <= s1_rows_q;
    end
    if (s_acc) begin
      prev_raw_q <= prev_mem[rd_addr];
    end
  end

  // Read qualifiers: valid bit, or forwarding from a write on the same edge.
  logic cur_ok_q;
  logic prev_ok_q;
  logic cur_fwd_q;
  logic prev_fwd_q;
  logic [ROWS-1:0] fwd_rows_q;

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      cur_ok_q   <= cur_vld_q[rd_addr];
      prev_ok_q  <= prev_vld_q[rd_addr];
      cur_fwd_q  <= cur_we && (s1_col_q == rd_addr);
      prev_fwd_q <= prev_we && (s1_col_q == rd_addr);
      fwd_rows_q <= s1_rows_q;
    end
  end

  logic [ROWS-1:0] cur_rows;
  logic [ROWS-1:0] prev_rows;

  assign cur_rows  = cur_fwd_q  ? fwd_rows_q : (cur_ok_q  ? cur_raw_q  : '0);
  assign prev_rows = prev_fwd_q ? fwd_rows_q : (prev_ok_q ? prev_raw_q : '0);

  // New-press check: lowest row pressed now but not before.
  logic [ROWS-1:0] fresh;
  logic            any_fresh;
  logic [8:0]      code_full;

  always_comb begin
    fresh     = s1_rows_q & ~prev_rows;
    any_fresh = |fresh;
    code_full = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (fresh[r]) begin
        code_full = 9'(r * COLUMNS) + 9'(s1_col_q);
      end
    end
  end

  // Hit tracking across one scan.
  logic [KeyW-1:0] hit_code_q;
  logic            hit_now;

  assign hit_now = !hit_seen_q && any_fresh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_seen_q <= 1'b0;
      hit_code_q <= '0;
    end else if (cur_we) begin
      if (s1_last_q) begin
        hit_seen_q <= 1'b0;
        hit_code_q <= '0;
      end else if (hit_now) begin
        hit_seen_q <= 1'b1;
        hit_code_q <= code_full[KeyW-1:0];
      end
    end
  end

  // Result item assembly.
  res_kind_e       res_kind;
  logic            res_press;
  logic [KeyW-1:0] res_code;
  logic            res_down;

  always_comb begin
    res_kind  = KindScan;
    res_press = 1'b0;
    res_code  = '0;
    res_down  = 1'b0;
    case (s1_op_q)
      OpQuery: begin
        res_kind = KindQuery;
        res_down = s1_inr_q && cur_rows[s1_row_q];
      end
      OpSample: begin
        res_press = hit_seen_q || hit_now;
        res_code  = hit_seen_q ? hit_code_q : (hit_now ? code_full[KeyW-1:0] : '0);
      end
      default: begin
        res_kind = KindScan;
      end
    endcase
  end

  // Output register.
  res_kind_e       m_kind_q;
  logic            m_press_q;
  logic [KeyW-1:0] m_code_q;
  logic            m_down_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (s1_fire && s1_res) begin
      m_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_res) begin
      m_kind_q  <= res_kind;
      m_press_q <= res_press;
      m_code_q  <= res_code;
      m_down_q  <= res_down;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = {{(OutDataW-KeyW-2){1'b0}}, m_down_q, m_code_q, m_press_q};

`ifndef ASSERT_OFF
  // Stage 1 only waits behind a full output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s1_go) |-> m_vld_q)
    else $error("stage 1 stalled with the output register empty");

  // The column counter never leaves the matrix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= LastCol)
    else $error("column counter out of range");

  // The last column of a scan starts the next scan with no hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_we && s1_last_q) |=> !hit_seen_q)
    else $error("hit state survived the end of a scan");

  // Without a hit the latched code stays clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hit_seen_q |-> (hit_code_q == '0))
    else $error("hit code set without a hit");
`endif

endmodule
